// ===== rtl/gamepad_report_to_events_defines.svh =====
// Assertion macros shared by the gamepad report block.
`ifndef GAMEPAD_REPORT_TO_EVENTS_DEFINES_SVH
`define GAMEPAD_REPORT_TO_EVENTS_DEFINES_SVH

// same-cycle implication
`define GPEV_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("gamepad_report_to_events: check failed");

// next-cycle implication
`define GPEV_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("gamepad_report_to_events: check failed");

`endif

// ===== rtl/gpev_pkg.sv =====
// Types, constants, microcode program and arithmetic helpers of the report block.
package gpev_pkg;

   localparam int BUTTON_BYTES = 3;
   localparam int NUM_BUTTONS  = BUTTON_BYTES * 8;
   localparam int NUM_AXES     = 8;
   localparam int NUM_STEPS    = NUM_BUTTONS + NUM_AXES;
   localparam int STEP_W       = $clog2(NUM_STEPS);

   localparam logic [15:0] GOOD_STATUS = 16'h013c;

   localparam logic [4:0] TOUCH_BUTTON  = 5'd20;
   localparam logic [4:0] MODE_BUTTON   = 5'd17;
   localparam logic [4:0] HIDDEN_BUTTON = 5'd22;

   localparam int TRIG_FULL = 32767;
   localparam int TRIG_MAX  = 255;
   localparam int TRIG_FRAC = TRIG_FULL - TRIG_MAX * 128;

   localparam logic [1:0] KIND_RELEASE = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_AXIS    = 2'd2;

   localparam logic [1:0] SRC_LEFT_X  = 2'd0;
   localparam logic [1:0] SRC_LEFT_Y  = 2'd1;
   localparam logic [1:0] SRC_RIGHT_X = 2'd2;
   localparam logic [1:0] SRC_RIGHT_Y = 2'd3;

   typedef struct packed {
      logic [15:0]        status_word;
      logic [23:0]        button_bits;
      logic [7:0]         trigger_left;
      logic [7:0]         trigger_right;
      logic signed [15:0] left_x_pos;
      logic signed [15:0] left_y_pos;
      logic signed [15:0] right_x_pos;
      logic signed [15:0] right_y_pos;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [4:0]         event_index;
      logic signed [15:0] axis_value;
      logic [7:0]         event_device;
      logic               last_event;
   } rsp_word_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] buttons;
      logic [7:0]             trig_left;
      logic [7:0]             trig_right;
      logic [15:0]            left_x;
      logic [15:0]            left_y;
      logic [15:0]            right_x;
      logic [15:0]            right_y;
   } prior_type;

   typedef enum logic [2:0] {
      OP_BUTTON,
      OP_TRIG,
      OP_PAD,
      OP_FREE,
      OP_STICK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] index;
      logic [1:0] src;
      logic       neg;
      logic       jump_end;
   } ucode_type;

   typedef struct packed {
      logic         hit;
      rsp_word_type word;
   } eval_type;

   function automatic ucode_type ucode_rom(logic [STEP_W-1:0] step);
      ucode_type  uc;
      logic [2:0] axis;
      uc.op       = OP_BUTTON;
      uc.index    = 5'(step);
      uc.src      = SRC_LEFT_X;
      uc.neg      = 1'b0;
      uc.jump_end = 1'b0;
      axis        = 3'(step - STEP_W'(NUM_BUTTONS));
      if (step >= STEP_W'(NUM_BUTTONS)) begin
         uc.index = {2'b00, axis};
         case (axis)
            3'd0: begin
               uc.op  = OP_TRIG;
               uc.src = SRC_LEFT_X;
            end
            3'd1: begin
               uc.op  = OP_TRIG;
               uc.src = SRC_LEFT_Y;
            end
            3'd2: begin
               uc.op  = OP_PAD;
               uc.src = SRC_LEFT_X;
            end
            3'd3: begin
               uc.op  = OP_PAD;
               uc.src = SRC_LEFT_Y;
               uc.neg = 1'b1;
            end
            3'd4: begin
               uc.op  = OP_FREE;
               uc.src = SRC_RIGHT_X;
            end
            3'd5: begin
               uc.op  = OP_FREE;
               uc.src = SRC_RIGHT_Y;
               uc.neg = 1'b1;
            end
            3'd6: begin
               uc.op  = OP_STICK;
               uc.src = SRC_LEFT_X;
            end
            3'd7: begin
               uc.op       = OP_STICK;
               uc.src      = SRC_LEFT_Y;
               uc.neg      = 1'b1;
               uc.jump_end = 1'b1;
            end
            default: begin
               uc.op = OP_FREE;
            end
         endcase
      end
      return uc;
   endfunction

   function automatic logic [15:0] scale_trigger(logic [7:0] t);
      logic [15:0] p;
      logic [15:0] q;
      p = 16'(t) * 16'(TRIG_FRAC);
      q = (p + 16'd1 + (p >> 8)) >> 8;
      return (16'(t) << 7) + q;
   endfunction

   function automatic logic [15:0] negate_y(logic [15:0] v);
      if (v == 16'h8000) begin
         return 16'h7fff;
      end
      return ~v + 16'd1;
   endfunction

endpackage

// ===== rtl/gpev_eval.sv =====
// Datapath of one microcode step: event condition, kind and value.
module gpev_eval (
   input  gpev_pkg::ucode_type    ctrl,
   input  gpev_pkg::req_word_type cap,
   input  gpev_pkg::prior_type    prior,
   input  logic [7:0]             device,
   output gpev_pkg::eval_type     ev
);
   import gpev_pkg::*;

   logic [NUM_BUTTONS-1:0] changed;
   logic [4:0]             bit_idx;
   logic                   hide;
   logic                   touch_now;
   logic                   touch_before;
   logic [15:0]            ax_now;
   logic [15:0]            ax_prior;
   logic [7:0]             trig_now;
   logic [7:0]             trig_prior;
   logic                   ax_changed;
   logic [15:0]            ax_value;

   assign changed      = cap.button_bits ^ prior.buttons;
   assign bit_idx      = 5'(NUM_BUTTONS - 1) - ctrl.index;
   assign hide         = changed[5'(NUM_BUTTONS - 1) - MODE_BUTTON];
   assign touch_now    = cap.button_bits[5'(NUM_BUTTONS - 1) - TOUCH_BUTTON];
   assign touch_before = prior.buttons[5'(NUM_BUTTONS - 1) - TOUCH_BUTTON];

   always_comb begin
      case (ctrl.src)
         SRC_LEFT_X: begin
            ax_now   = cap.left_x_pos;
            ax_prior = prior.left_x;
         end
         SRC_LEFT_Y: begin
            ax_now   = cap.left_y_pos;
            ax_prior = prior.left_y;
         end
         SRC_RIGHT_X: begin
            ax_now   = cap.right_x_pos;
            ax_prior = prior.right_x;
         end
         SRC_RIGHT_Y: begin
            ax_now   = cap.right_y_pos;
            ax_prior = prior.right_y;
         end
         default: begin
            ax_now   = cap.left_x_pos;
            ax_prior = prior.left_x;
         end
      endcase
   end

   assign trig_now   = ctrl.src[0] ? cap.trigger_right : cap.trigger_left;
   assign trig_prior = ctrl.src[0] ? prior.trig_right : prior.trig_left;
   assign ax_changed = ax_now != ax_prior;
   assign ax_value   = ctrl.neg ? negate_y(ax_now) : ax_now;

   always_comb begin
      ev.hit                = 1'b0;
      ev.word.event_kind    = KIND_AXIS;
      ev.word.event_index   = ctrl.index;
      ev.word.axis_value    = ax_value;
      ev.word.event_device  = device;
      ev.word.last_event    = 1'b0;
      case (ctrl.op)
         OP_BUTTON: begin
            ev.hit = changed[bit_idx] && !(hide && ctrl.index == HIDDEN_BUTTON);
            ev.word.event_kind = cap.button_bits[bit_idx] ? KIND_PRESS : KIND_RELEASE;
            ev.word.axis_value = '0;
         end
         OP_TRIG: begin
            ev.hit = trig_now != trig_prior;
            ev.word.axis_value = scale_trigger(trig_now);
         end
         OP_PAD: begin
            ev.hit = (touch_now || touch_before) && ax_changed;
         end
         OP_FREE: begin
            ev.hit = ax_changed;
         end
         OP_STICK: begin
            if (!touch_now) begin
               ev.hit = ax_changed;
            end else begin
               ev.hit = !touch_before;
               ev.word.axis_value = '0;
            end
         end
         default: begin
            ev.hit = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/gamepad_report_to_events.sv =====
// Top level: report capture, microcode sequencer, event hold and output register.
// A report with a bad status word is taken and dropped. A good report passes
// capture, 32 program steps (one per cycle, set by the step counter walking the
// program table, unless result stall holds a step), one flush. An event reaches
// the output in the cycle after the step that finds the next event; the final
// event in the cycle after the flush. Result stall stretches the steps.
// Reset is synchronous: idle, output empty, stored report and device number zero.
`include "gamepad_report_to_events_defines.svh"

module gamepad_report_to_events (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gpev_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gpev_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import gpev_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   req_word_type      cap_ff, cap_in;
   prior_type         prior_ff, prior_in;
   rsp_word_type      hold_ff, hold_in;
   logic              hold_valid_ff, hold_valid_in;
   rsp_word_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        device_ff, device_in;

   ucode_type ctrl;
   eval_type  ev;
   logic      req_accept;
   logic      out_free;

   assign ctrl       = ucode_rom(step_ff);
   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;
   assign csr_ready  = 1'b1;

   gpev_eval u_eval (
      .ctrl   (ctrl),
      .cap    (cap_ff),
      .prior  (prior_ff),
      .device (device_ff),
      .ev     (ev)
   );

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cap_in        = cap_ff;
      prior_in      = prior_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      device_in     = device_ff;
      if (csr_valid && csr_ready) begin
         device_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_word.status_word == GOOD_STATUS) begin
               cap_in   = req_word;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!(ev.hit && hold_valid_ff && !out_free)) begin
               if (ev.hit) begin
                  if (hold_valid_ff) begin
                     rsp_in       = hold_ff;
                     rsp_valid_in = 1'b1;
                  end
                  hold_in       = ev.word;
                  hold_valid_in = 1'b1;
               end
               if (ctrl.jump_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_in            = hold_ff;
                  rsp_in.last_event = 1'b1;
                  rsp_valid_in      = 1'b1;
               end
               hold_valid_in    = 1'b0;
               prior_in.buttons    = cap_ff.button_bits;
               prior_in.trig_left  = cap_ff.trigger_left;
               prior_in.trig_right = cap_ff.trigger_right;
               prior_in.left_x     = cap_ff.left_x_pos;
               prior_in.left_y     = cap_ff.left_y_pos;
               prior_in.right_x    = cap_ff.right_x_pos;
               prior_in.right_y    = cap_ff.right_y_pos;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         prior_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         device_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         prior_ff      <= prior_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         device_ff     <= device_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff  <= cap_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   `GPEV_ASSERT_IMPLIES(a_idle_no_hold, clock, reset, state_ff == ST_IDLE, !hold_valid_ff)
   `GPEV_ASSERT_NEXT(a_bad_status_keeps_state, clock, reset, req_accept && req_word.status_word != GOOD_STATUS, $stable(prior_ff))
   `GPEV_ASSERT_NEXT(a_good_starts_program, clock, reset, req_accept && req_word.status_word == GOOD_STATUS, state_ff == ST_RUN && step_ff == '0)
   `GPEV_ASSERT_NEXT(a_step_holds_on_stall, clock, reset, state_ff == ST_RUN && ev.hit && hold_valid_ff && rsp_valid_ff && rsp_stall, $stable(step_ff))

endmodule

// ===== tb/gpev_checker.sv =====
// Watches the report and event channels, predicts each event word and compares it.
`timescale 1ns / 100ps

module gpev_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  gpev_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  gpev_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [7:0]             csr_data,
   output int                     fail_count,
   output int                     pending_count
);
   import gpev_pkg::*;

   localparam int AXIS_TRIG_LEFT  = 0;
   localparam int AXIS_TRIG_RIGHT = 1;
   localparam int AXIS_PAD_X      = 2;
   localparam int AXIS_PAD_Y      = 3;
   localparam int AXIS_RIGHT_X    = 4;
   localparam int AXIS_RIGHT_Y    = 5;
   localparam int AXIS_STICK_X    = 6;
   localparam int AXIS_STICK_Y    = 7;
   localparam int MAX_EVENTS      = 32;

   logic [NUM_BUTTONS-1:0] held_buttons;
   logic [7:0]             held_trig_left;
   logic [7:0]             held_trig_right;
   logic [15:0]            held_left_x;
   logic [15:0]            held_left_y;
   logic [15:0]            held_right_x;
   logic [15:0]            held_right_y;
   logic [7:0]             device_id;
   rsp_word_type           pending_events [$];

   function automatic logic [15:0] flip_y(logic [15:0] v);
      if (v == 16'h8000) begin
         return 16'h7fff;
      end
      return -v;
   endfunction

   function automatic logic [15:0] trigger_level(logic [7:0] t);
      return 16'((int'(t) * TRIG_FULL) / TRIG_MAX);
   endfunction

   function automatic rsp_word_type make_event(logic [1:0] kind, int idx, logic [15:0] value);
      rsp_word_type e;
      e.event_kind   = kind;
      e.event_index  = 5'(idx);
      e.axis_value   = value;
      e.event_device = device_id;
      e.last_event   = 1'b0;
      return e;
   endfunction

   task automatic predict_events(input req_word_type r);
      rsp_word_type           evs [MAX_EVENTS];
      int                     cnt;
      int                     n;
      logic [NUM_BUTTONS-1:0] changed;
      logic                   hide;
      logic                   touch_now;
      logic                   touch_was;
      logic                   lx_moved;
      logic                   ly_moved;
      cnt = 0;
      if (r.status_word != GOOD_STATUS) begin
         return;
      end
      changed = r.button_bits ^ held_buttons;
      hide    = changed[NUM_BUTTONS-1-MODE_BUTTON];
      for (n = 0; n < NUM_BUTTONS; n++) begin
         if (changed[NUM_BUTTONS-1-n] && !(hide && n == HIDDEN_BUTTON)) begin
            evs[cnt] = make_event(r.button_bits[NUM_BUTTONS-1-n] ? KIND_PRESS : KIND_RELEASE,
                                  n, 16'd0);
            cnt++;
         end
      end
      if (r.trigger_left != held_trig_left) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_TRIG_LEFT, trigger_level(r.trigger_left));
         cnt++;
      end
      if (r.trigger_right != held_trig_right) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_TRIG_RIGHT, trigger_level(r.trigger_right));
         cnt++;
      end
      touch_now = r.button_bits[NUM_BUTTONS-1-TOUCH_BUTTON];
      touch_was = held_buttons[NUM_BUTTONS-1-TOUCH_BUTTON];
      lx_moved  = r.left_x_pos != held_left_x;
      ly_moved  = r.left_y_pos != held_left_y;
      if ((touch_now || touch_was) && lx_moved) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_PAD_X, r.left_x_pos);
         cnt++;
      end
      if ((touch_now || touch_was) && ly_moved) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_PAD_Y, flip_y(r.left_y_pos));
         cnt++;
      end
      if (r.right_x_pos != held_right_x) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_RIGHT_X, r.right_x_pos);
         cnt++;
      end
      if (r.right_y_pos != held_right_y) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_RIGHT_Y, flip_y(r.right_y_pos));
         cnt++;
      end
      if (!touch_now) begin
         if (lx_moved) begin
            evs[cnt] = make_event(KIND_AXIS, AXIS_STICK_X, r.left_x_pos);
            cnt++;
         end
         if (ly_moved) begin
            evs[cnt] = make_event(KIND_AXIS, AXIS_STICK_Y, flip_y(r.left_y_pos));
            cnt++;
         end
      end else if (!touch_was) begin
         evs[cnt] = make_event(KIND_AXIS, AXIS_STICK_X, 16'd0);
         cnt++;
         evs[cnt] = make_event(KIND_AXIS, AXIS_STICK_Y, 16'd0);
         cnt++;
      end
      for (n = 0; n < cnt; n++) begin
         if (n == cnt - 1) begin
            evs[n].last_event = 1'b1;
         end
         pending_events.push_back(evs[n]);
      end
      held_buttons    = r.button_bits;
      held_trig_left  = r.trigger_left;
      held_trig_right = r.trigger_right;
      held_left_x     = r.left_x_pos;
      held_left_y     = r.left_y_pos;
      held_right_x    = r.right_x_pos;
      held_right_y    = r.right_y_pos;
   endtask

   task automatic compare_field(input string what, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         held_buttons    = '0;
         held_trig_left  = '0;
         held_trig_right = '0;
         held_left_x     = '0;
         held_left_y     = '0;
         held_right_x    = '0;
         held_right_y    = '0;
         device_id       = '0;
         fail_count      = 0;
         pending_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            device_id = csr_data;
         end
         if (req_valid && !req_stall) begin
            predict_events(req_word);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               fail_count++;
               $display("%0t: event expected none actual %0h", $time, rsp_word);
            end else begin
               want = pending_events.pop_front();
               compare_field("event_kind", want.event_kind, rsp_word.event_kind);
               compare_field("event_index", want.event_index, rsp_word.event_index);
               compare_field("axis_value", want.axis_value, rsp_word.axis_value);
               compare_field("event_device", want.event_device, rsp_word.event_device);
               compare_field("last_event", want.last_event, rsp_word.last_event);
            end
         end
      end
      pending_count = pending_events.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the report block's testbench: clock, reset, report stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import gpev_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_REPORTS = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;
   int           fail_count;
   int           pending_count;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_stall_pct;
   req_word_type last_good;

   gamepad_report_to_events dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   gpev_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic req_word_type good_report(logic [23:0] buttons, logic [7:0] tl,
                                                logic [7:0] tr, logic [15:0] lx,
                                                logic [15:0] ly, logic [15:0] rx,
                                                logic [15:0] ry);
      req_word_type r;
      r.status_word   = GOOD_STATUS;
      r.button_bits   = buttons;
      r.trigger_left  = tl;
      r.trigger_right = tr;
      r.left_x_pos    = lx;
      r.left_y_pos    = ly;
      r.right_x_pos   = rx;
      r.right_y_pos   = ry;
      return r;
   endfunction

   function automatic logic [15:0] pick_axis(logic [15:0] old);
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4: return 16'($urandom);
         default: return old;
      endcase
   endfunction

   function automatic req_word_type random_report();
      req_word_type r;
      r = last_good;
      r.status_word = GOOD_STATUS;
      case ($urandom_range(9))
         0: r.button_bits = 24'($urandom);
         1, 2, 3: r.button_bits ^= 24'(1 << $urandom_range(NUM_BUTTONS - 1));
         4: r.button_bits ^= 24'($urandom) & 24'($urandom) & 24'($urandom);
         default: r.button_bits = r.button_bits;
      endcase
      if ($urandom_range(3) == 0) begin
         r.button_bits[NUM_BUTTONS-1-TOUCH_BUTTON] ^= 1'b1;
      end
      if ($urandom_range(5) == 0) begin
         r.button_bits[NUM_BUTTONS-1-MODE_BUTTON] ^= 1'b1;
      end
      if ($urandom_range(5) == 0) begin
         r.button_bits[NUM_BUTTONS-1-HIDDEN_BUTTON] ^= 1'b1;
      end
      if ($urandom_range(2) == 0) begin
         r.trigger_left = 8'($urandom);
      end
      if ($urandom_range(2) == 0) begin
         r.trigger_right = 8'($urandom);
      end
      r.left_x_pos  = pick_axis(r.left_x_pos);
      r.left_y_pos  = pick_axis(r.left_y_pos);
      r.right_x_pos = pick_axis(r.right_x_pos);
      r.right_y_pos = pick_axis(r.right_y_pos);
      return r;
   endfunction

   function automatic req_word_type noise_report();
      req_word_type r;
      r = random_report();
      if ($urandom_range(1) == 0) begin
         r.status_word = GOOD_STATUS ^ 16'(1 << $urandom_range(15));
      end else begin
         r.status_word = 16'($urandom);
      end
      if (r.status_word == GOOD_STATUS) begin
         r.status_word = ~GOOD_STATUS;
      end
      return r;
   endfunction

   task automatic send_report(input req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (w.status_word == GOOD_STATUS) begin
         last_good = w;
      end
   endtask

   task automatic hold_off();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_device(input logic [7:0] dev);
      hold_off();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= dev;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input logic [7:0] dev);
      int i;
      write_device(dev);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (i = 0; i < PHASE_REPORTS; i++) begin
         if (i == PHASE_REPORTS / 2) begin
            hold_off();
         end
         while ($urandom_range(6) == 0) begin
            send_report(noise_report());
         end
         send_report(random_report());
      end
   endtask

   initial begin
      req_word_type r;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      last_good      = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      r = good_report(24'hffffff, 8'hff, 8'hff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      r.status_word = 16'h3c01;
      send_report(r);
      send_report(good_report(24'h000000, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000));
      send_report(good_report(24'hffffff, 8'hff, 8'hff, 16'h8000, 16'h8000, 16'h7fff,
                              16'h8000));
      send_report(good_report(24'hffffff, 8'hff, 8'hff, 16'h8000, 16'h8000, 16'h7fff,
                              16'h8000));
      r = good_report(24'h000000, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      r.status_word = 16'hffff;
      send_report(r);
      send_report(good_report(24'h000000, 8'h00, 8'h01, 16'h7fff, 16'h7fff, 16'h8000,
                              16'h0001));
      send_report(good_report(24'h000002, 8'h80, 8'hfe, 16'h7fff, 16'h7fff, 16'h8000,
                              16'h0001));
      send_report(good_report(24'h000040, 8'h80, 8'hfe, 16'h7fff, 16'h7fff, 16'h8000,
                              16'h0001));
      send_report(good_report(24'h000048, 8'h80, 8'hfe, 16'h1234, 16'hffff, 16'h8000,
                              16'h0001));

      write_device(8'hff);
      send_report(good_report(24'h000008, 8'h01, 8'hfe, 16'h5678, 16'h0000, 16'h0001,
                              16'h8000));
      send_report(good_report(24'h000008, 8'h01, 8'hfe, 16'h5678, 16'h0000, 16'h0001,
                              16'h8000));
      send_report(good_report(24'h000000, 8'h01, 8'hfe, 16'h8000, 16'h8000, 16'h0001,
                              16'h8000));
      send_report(good_report(24'h800000, 8'hff, 8'h00, 16'h8000, 16'h0001, 16'h7fff,
                              16'h7fff));
      send_report(good_report(24'h7ffff7, 8'h00, 8'hff, 16'h0001, 16'h8000, 16'hffff,
                              16'hffff));
      r = good_report(24'h000000, 8'h55, 8'haa, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      r.status_word = 16'h013d;
      send_report(r);
      r.status_word = 16'h003c;
      send_report(r);
      r.status_word = 16'h0000;
      send_report(r);
      send_report(good_report(24'h000002, 8'h00, 8'hff, 16'h0001, 16'h8000, 16'hffff,
                              16'hffff));

      run_phase(0, 0, 8'($urandom));
      run_phase(71, 0, 8'h00);
      run_phase(0, 71, 8'($urandom));
      run_phase(37, 37, 8'($urandom));

      hold_off();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
